// ===== hw/rtl/evel_pkg.sv =====
package evel_pkg;

	// widths of the shared datapath
	localparam int RF_W   = 40;              // filter state, signed fixed point
	localparam int MUL_W  = 27;              // conversion multiplier constant
	localparam int ACC_W  = RF_W + MUL_W;    // shared accumulator / dividend
	localparam int DVS_W  = 35;              // divisor: 32-bit interval times 3-bit edges
	localparam int ITER_W = $clog2(ACC_W + 1);
	localparam int FR_W   = 33;              // filtered_rate output width

	// filter weights, q.16
	localparam logic [15:0] W_HI = 16'd62259;
	localparam logic [15:0] W_LO = 16'd3277;
	localparam int FILT_SHIFT = 16;
	localparam int FILT_ROUND = 32768;

	// pulse rate scaling and unit conversion
	localparam int MS_PER_S = 1000;
	localparam logic [MUL_W-1:0] MUL_REV_S   = 27'd1;
	localparam logic [MUL_W-1:0] MUL_REV_MIN = 27'd60;
	localparam logic [MUL_W-1:0] MUL_RAD_S   = 27'd105414357;  // 2*pi in q.24
	localparam int TWO_PI_SHIFT = 24;

	localparam logic signed [RF_W-1:0] RF_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [RF_W-1:0] RF_MIN = 40'sh80_0000_0000;

	// configuration register indexes
	localparam logic [1:0] REG_COUNTING_EDGES = 2'd0;
	localparam logic [1:0] REG_PULSES_PER_REV = 2'd1;
	localparam logic [1:0] REG_UNIT_MODE      = 2'd2;

	// unit_mode codes
	localparam logic [1:0] UNIT_REV_S   = 2'd0;
	localparam logic [1:0] UNIT_REV_MIN = 2'd1;
	localparam logic [1:0] UNIT_RAD_S   = 2'd2;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_PREP  = 9'b000000010,
		ST_RDIV  = 9'b000000100,
		ST_FILT  = 9'b000001000,
		ST_FEND  = 9'b000010000,
		ST_CINIT = 9'b000100000,
		ST_CMUL  = 9'b001000000,
		ST_CLOAD = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} div_ctrl_t;

endpackage

// ===== hw/rtl/evel_divider.sv =====
module evel_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  evel_pkg::div_ctrl_t            ctrl,
	input  logic [evel_pkg::ACC_W-1:0]     dividend,
	input  logic [evel_pkg::DVS_W-1:0]     divisor,
	output logic [evel_pkg::ACC_W-1:0]     quotient,
	output logic                           done
);

	// restoring division, one quotient bit per cycle; the dividend is expected
	// left-aligned so that the quotient lands in the low ctrl.iters bits
	logic [evel_pkg::ACC_W-1:0]  dvd_q;
	logic [evel_pkg::DVS_W-1:0]  dvs_q;
	logic [evel_pkg::DVS_W-1:0]  rem_q;
	logic [evel_pkg::ITER_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [evel_pkg::DVS_W:0]    trial;
	logic [evel_pkg::DVS_W:0]    diff;
	logic                        ge;

	always_comb begin
		trial = {rem_q, dvd_q[evel_pkg::ACC_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = !diff[evel_pkg::DVS_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctrl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == evel_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[evel_pkg::ACC_W-2:0], ge};
			rem_q <= ge ? diff[evel_pkg::DVS_W-1:0] : trial[evel_pkg::DVS_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/encoder_velocity_estimator_top.sv =====
// Encoder velocity estimator. Each input transaction carries a free-running
// encoder count and a millisecond time stamp; each one yields exactly one output
// transaction. The first transaction after reset only records count and time and
// reports the (zero) filter. Later ones take the signed count change (wrapping in
// COUNTER_BITS) over the elapsed milliseconds (32-bit wrap), form the pulse rate
// change*1000/(elapsed*counting_edges) truncated toward zero, and run it through
// a 0.95/0.05 exponential filter with q.16 weights and round-half-up. The
// filtered rate (signed q.FRACTION_BITS, saturated to 33 bits) comes out with
// the same value divided by pulses_per_rev and scaled to rev/s, rev/min or rad/s
// (signed q.FRACTION_BITS, truncated toward zero, saturated to 40 bits). A zero
// interval holds the filter and last sample and sets the zero_interval flag in
// tuser. Zero counting_edges or pulses_per_rev act as one; unit mode three acts
// as rev/s. The work runs on one shared restoring divider (one quotient bit per
// cycle) and one shared shift-add accumulator (one multiplier bit per cycle); the
// conversion divide over the full accumulator width dominates the time of an
// item. The block takes one item at a time: s_tready is high only while idle,
// which it is again in the cycle after the result is loaded. A finished result
// waits in the output register without stopping the next item from being
// accepted; a result that cannot be loaded because the previous one is still
// waiting stalls the block in the done state. Configuration writes take effect
// at once and belong to idle periods.
module encoder_velocity_estimator_top #(
	parameter int COUNTER_BITS  = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration writes, index 0 counting_edges, 1 pulses_per_rev, 2 unit_mode
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,

	// sample input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // [15:0] count_value, [47:16] now_ms

	// velocity output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,    // [32:0] filtered_rate, [72:33] converted_speed
	output logic [0:0]  m_tuser     // [0] zero_interval
);

	localparam int ACC_W  = evel_pkg::ACC_W;
	localparam int RF_W   = evel_pkg::RF_W;
	localparam int DVS_W  = evel_pkg::DVS_W;
	localparam int ITER_W = evel_pkg::ITER_W;
	localparam int FR_W   = evel_pkg::FR_W;
	// count change times 1000 fits here: 2^COUNTER_BITS * 1000 < 2^(COUNTER_BITS+10)
	localparam int NUM_W  = COUNTER_BITS + 10;
	localparam int QX_W   = (NUM_W > RF_W + 1) ? NUM_W : RF_W + 1;

	localparam logic signed [ACC_W-1:0] ROUND_X  = ACC_W'(evel_pkg::FILT_ROUND);
	localparam logic signed [ACC_W-1:0] RF_MAX_X = ACC_W'(evel_pkg::RF_MAX);
	localparam logic signed [ACC_W-1:0] RF_MIN_X = ACC_W'(evel_pkg::RF_MIN);
	localparam logic signed [RF_W-1:0]  FR_MAX_X = 40'sd4294967295;
	localparam logic signed [RF_W-1:0]  FR_MIN_X = -40'sd4294967296;
	// rate magnitude that fits once scaled to q.FRACTION_BITS only as a negative value
	localparam logic [QX_W-1:0] RATE_LIM = QX_W'(1) << (RF_W - 1 - FRACTION_BITS);
	localparam logic [ACC_W-1:0] CONV_LIM = ACC_W'(1) << (RF_W - 1);

	// configuration registers
	logic [2:0]  edges_cfg_q;
	logic [15:0] ppr_cfg_q;
	logic [1:0]  unit_cfg_q;

	// estimator state
	logic [COUNTER_BITS-1:0]  prev_count_q;
	logic [31:0]              prev_time_q;
	logic signed [RF_W-1:0]   rf_q;
	logic                     primed_q;

	// per-item working registers
	evel_pkg::state_t         state_q;
	logic [COUNTER_BITS-1:0]  cnt_q;
	logic [31:0]              now_q;
	logic                     zero_q;
	logic                     dneg_q;
	logic signed [RF_W-1:0]   x_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ITER_W-1:0]        iter_q;
	logic [RF_W-1:0]          rmag_q;
	logic                     rneg_q;
	logic [evel_pkg::MUL_W-1:0] mul_q;
	logic                     shift_q;

	// output register
	logic                     out_valid_q;
	logic [FR_W-1:0]          out_fr_q;
	logic [RF_W-1:0]          out_conv_q;
	logic                     out_zero_q;

	// divider hookup
	evel_pkg::div_ctrl_t      div_ctrl;
	logic [ACC_W-1:0]         div_dividend;
	logic [DVS_W-1:0]         div_divisor;
	logic [ACC_W-1:0]         div_quot;
	logic                     div_done;

	// prep stage: count change and interval
	logic [31:0]              elapsed;
	logic [COUNTER_BITS-1:0]  dcount;
	logic                     dneg;
	logic [COUNTER_BITS:0]    dmag;
	logic [NUM_W-1:0]         rate_num;
	logic [2:0]               edges;
	logic [DVS_W-1:0]         rate_den;
	logic [15:0]              ppr_eff;

	// rate saturation
	logic [QX_W-1:0]          rate_q;
	logic [RF_W-1:0]          x_mag;
	logic signed [RF_W-1:0]   x_next;

	// shared accumulator
	logic signed [ACC_W-1:0]  add_a;
	logic signed [ACC_W-1:0]  add_b;
	logic signed [ACC_W-1:0]  acc_sum;

	// filter update
	logic signed [ACC_W-1:0]  fsum;
	logic signed [ACC_W-1:0]  fnext;
	logic signed [RF_W-1:0]   rf_next;

	// conversion
	logic [RF_W-1:0]          rmag;
	logic [ACC_W-1:0]         conv_res;
	logic [ACC_W-1:0]         conv_lim;
	logic [ACC_W-1:0]         conv_sat;
	logic [RF_W-1:0]          conv_out;
	logic [FR_W-1:0]          fr_out;

	logic                     in_fire;
	logic                     out_load;

	assign s_tready = (state_q == evel_pkg::ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == evel_pkg::ST_DONE) && (!out_valid_q || m_tready);

	// count change, wrap-aware, and the rate numerator/denominator
	always_comb begin
		elapsed  = now_q - prev_time_q;
		dcount   = cnt_q - prev_count_q;
		dneg     = dcount[COUNTER_BITS-1];
		dmag     = dneg ? (((COUNTER_BITS + 1)'(1) << COUNTER_BITS) - {1'b0, dcount})
		                : {1'b0, dcount};
		rate_num = NUM_W'(dmag) * NUM_W'(evel_pkg::MS_PER_S);
		edges    = (edges_cfg_q == 3'd0) ? 3'd1 : edges_cfg_q;
		rate_den = DVS_W'(elapsed) * DVS_W'(edges);
		ppr_eff  = (ppr_cfg_q == 16'd0) ? 16'd1 : ppr_cfg_q;
	end

	// one divider serves both the rate and the unit conversion
	always_comb begin
		div_ctrl.start = 1'b0;
		div_ctrl.iters = ITER_W'(ACC_W);
		div_dividend   = acc_q;
		div_divisor    = DVS_W'(ppr_eff);
		if (state_q == evel_pkg::ST_PREP) begin
			// left-align the numerator so the quotient ends in the low bits
			div_ctrl.start = primed_q && (elapsed != 32'd0);
			div_ctrl.iters = ITER_W'(NUM_W);
			div_dividend   = ACC_W'(rate_num) << (ACC_W - NUM_W);
			div_divisor    = rate_den;
		end else if (state_q == evel_pkg::ST_CLOAD) begin
			div_ctrl.start = 1'b1;
		end
	end

	evel_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	// signed pulse rate, scaled to q.FRACTION_BITS with saturation
	always_comb begin
		rate_q = QX_W'(div_quot[NUM_W-1:0]);
		x_mag  = RF_W'(rate_q << FRACTION_BITS);
		if (!dneg_q && rate_q >= RATE_LIM) begin
			x_next = evel_pkg::RF_MAX;
		end else if (dneg_q && rate_q > RATE_LIM) begin
			x_next = evel_pkg::RF_MIN;
		end else begin
			x_next = dneg_q ? -signed'(x_mag) : signed'(x_mag);
		end
	end

	// shared shift-add unit: msb-first, one multiplier bit per cycle
	always_comb begin
		add_a = '0;
		add_b = '0;
		if (state_q == evel_pkg::ST_FILT) begin
			if (evel_pkg::W_HI[iter_q[3:0]]) begin
				add_a = ACC_W'(rf_q);
			end
			if (evel_pkg::W_LO[iter_q[3:0]]) begin
				add_b = ACC_W'(x_q);
			end
		end else if (mul_q[iter_q[4:0]]) begin
			add_a = signed'(ACC_W'(rmag_q));
		end
		acc_sum = (acc_q <<< 1) + add_a + add_b;
	end

	// filter: round half up, floor by 2^16, clamp to the state width
	always_comb begin
		fsum  = acc_q + ROUND_X;
		fnext = fsum >>> evel_pkg::FILT_SHIFT;
		if (fnext > RF_MAX_X) begin
			rf_next = evel_pkg::RF_MAX;
		end else if (fnext < RF_MIN_X) begin
			rf_next = evel_pkg::RF_MIN;
		end else begin
			rf_next = fnext[RF_W-1:0];
		end
	end

	// conversion result and output saturation
	always_comb begin
		rmag     = rf_q[RF_W-1] ? RF_W'(-rf_q) : RF_W'(rf_q);
		conv_res = shift_q ? (div_quot >> evel_pkg::TWO_PI_SHIFT) : div_quot;
		conv_lim = rneg_q ? CONV_LIM : (CONV_LIM - 1'b1);
		conv_sat = (conv_res > conv_lim) ? conv_lim : conv_res;
		conv_out = rneg_q ? RF_W'(-conv_sat) : RF_W'(conv_sat);
		if (rf_q > FR_MAX_X) begin
			fr_out = FR_MAX_X[FR_W-1:0];
		end else if (rf_q < FR_MIN_X) begin
			fr_out = FR_MIN_X[FR_W-1:0];
		end else begin
			fr_out = rf_q[FR_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_cfg_q <= 3'd4;
			ppr_cfg_q   <= 16'd1;
			unit_cfg_q  <= evel_pkg::UNIT_REV_S;
		end else if (cfg_we) begin
			case (cfg_addr)
				evel_pkg::REG_COUNTING_EDGES: edges_cfg_q <= cfg_wdata[2:0];
				evel_pkg::REG_PULSES_PER_REV: ppr_cfg_q   <= cfg_wdata;
				evel_pkg::REG_UNIT_MODE:      unit_cfg_q  <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// sequencer and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= evel_pkg::ST_IDLE;
			prev_count_q <= '0;
			prev_time_q  <= '0;
			rf_q         <= '0;
			primed_q     <= 1'b0;
			iter_q       <= '0;
		end else begin
			case (state_q)
				evel_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= evel_pkg::ST_PREP;
					end
				end
				evel_pkg::ST_PREP: begin
					if (!primed_q) begin
						// first sample only records
						prev_count_q <= cnt_q;
						prev_time_q  <= now_q;
						primed_q     <= 1'b1;
						state_q      <= evel_pkg::ST_CINIT;
					end else if (elapsed == 32'd0) begin
						// hold filter and last sample
						state_q <= evel_pkg::ST_CINIT;
					end else begin
						prev_count_q <= cnt_q;
						prev_time_q  <= now_q;
						state_q      <= evel_pkg::ST_RDIV;
					end
				end
				evel_pkg::ST_RDIV: begin
					if (div_done) begin
						iter_q  <= ITER_W'(15);
						state_q <= evel_pkg::ST_FILT;
					end
				end
				evel_pkg::ST_FILT: begin
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						state_q <= evel_pkg::ST_FEND;
					end
				end
				evel_pkg::ST_FEND: begin
					rf_q    <= rf_next;
					state_q <= evel_pkg::ST_CINIT;
				end
				evel_pkg::ST_CINIT: begin
					iter_q  <= ITER_W'(evel_pkg::MUL_W - 1);
					state_q <= evel_pkg::ST_CMUL;
				end
				evel_pkg::ST_CMUL: begin
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						state_q <= evel_pkg::ST_CLOAD;
					end
				end
				evel_pkg::ST_CLOAD: begin
					// all ones in iter_q marks the finished conversion divide
					iter_q  <= '0;
					state_q <= evel_pkg::ST_DONE;
				end
				evel_pkg::ST_DONE: begin
					// divider still running until done; then wait for the output slot
					if (div_done) begin
						iter_q <= '1;
					end
					if (iter_q == '1 && out_load) begin
						state_q <= evel_pkg::ST_IDLE;
					end
				end
				default: state_q <= evel_pkg::ST_IDLE;
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cnt_q <= COUNTER_BITS'(s_tdata[15:0]);
			now_q <= s_tdata[47:16];
		end
		case (state_q)
			evel_pkg::ST_PREP: begin
				dneg_q <= dneg;
				zero_q <= primed_q && (elapsed == 32'd0);
			end
			evel_pkg::ST_RDIV: begin
				x_q   <= x_next;
				acc_q <= '0;
			end
			evel_pkg::ST_FILT: begin
				acc_q <= acc_sum;
			end
			evel_pkg::ST_CINIT: begin
				rmag_q <= rmag;
				rneg_q <= rf_q[RF_W-1];
				acc_q  <= '0;
				case (unit_cfg_q)
					evel_pkg::UNIT_REV_MIN: begin
						mul_q   <= evel_pkg::MUL_REV_MIN;
						shift_q <= 1'b0;
					end
					evel_pkg::UNIT_RAD_S: begin
						mul_q   <= evel_pkg::MUL_RAD_S;
						shift_q <= 1'b1;
					end
					default: begin
						mul_q   <= evel_pkg::MUL_REV_S;
						shift_q <= 1'b0;
					end
				endcase
			end
			evel_pkg::ST_CMUL: begin
				acc_q <= acc_sum;
			end
			default: ;
		endcase
	end

	// output register: holds one result while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load && iter_q == '1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && iter_q == '1) begin
			out_fr_q   <= fr_out;
			out_conv_q <= conv_out;
			out_zero_q <= zero_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {7'd0, out_conv_q, out_fr_q};
	assign m_tuser[0] = out_zero_q;

endmodule

// ===== verif/encoder_velocity_estimator_top_tb.sv =====
module encoder_velocity_estimator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W = 16;
	localparam int FRAC  = 8;
	// settings visited by the random part, idling phase changes every two of them
	localparam int N_SETTINGS  = 8;
	localparam int PER_SETTING = 200;
	// give the tail plenty of margin beyond the longest item
	localparam int TAIL_CYCLES = 400;

	// -------------------------------------------------------------------------
	// scoreboard: keeps its own copy of the estimator state and registers,
	// predicts one velocity result per accepted sample transaction
	// -------------------------------------------------------------------------
	class velocity_scoreboard;
		localparam longint RF_HI = longint'(evel_pkg::RF_MAX);
		localparam longint RF_LO = longint'(evel_pkg::RF_MIN);
		localparam longint FR_HI = (longint'(1) <<< (evel_pkg::FR_W - 1)) - 1;
		localparam longint FR_LO = -(longint'(1) <<< (evel_pkg::FR_W - 1));

		typedef struct packed {
			logic [32:0] rate;
			logic [39:0] speed;
			logic        zero;
		} velocity_t;

		// register copies
		logic [2:0]  edges_r;
		logic [15:0] ppr_r;
		logic [1:0]  unit_r;
		// estimator state
		logic [CNT_W-1:0] prev_cnt;
		logic [31:0]      last_ms;
		longint           filt;
		bit               primed;

		velocity_t expected_velocity[$];
		int errors;
		int n_checked;
		int n_zero;
		int n_sat;

		function new();
			edges_r    = 3'd4;
			ppr_r      = 16'd1;
			unit_r     = evel_pkg::UNIT_REV_S;
			prev_cnt   = '0;
			last_ms    = '0;
			filt       = 0;
			primed     = 1'b0;
			errors     = 0;
			n_checked  = 0;
			n_zero     = 0;
			n_sat      = 0;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [15:0] val);
			case (idx)
				evel_pkg::REG_COUNTING_EDGES: edges_r = val[2:0];
				evel_pkg::REG_PULSES_PER_REV: ppr_r = val;
				evel_pkg::REG_UNIT_MODE:      unit_r = val[1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_velocity.size();
		endfunction

		function void note_sample(input logic [CNT_W-1:0] cnt, input logic [31:0] ms);
			logic [31:0]      elapsed;
			logic [CNT_W-1:0] delta;
			longint unsigned  mag, quo, per, q, r, lim, res, mul;
			longint           rate, x, acc, fr;
			int               sh;
			velocity_t        v;
			v = '0;
			if (!primed) begin
				// first sample after reset only records
				prev_cnt = cnt;
				last_ms  = ms;
				primed   = 1'b1;
			end else begin
				elapsed = ms - last_ms;
				if (elapsed == '0) begin
					// hold filter and last sample
					v.zero = 1'b1;
					n_zero++;
				end else begin
					delta = cnt - prev_cnt;
					mag   = delta[CNT_W-1] ? (64'd1 << CNT_W) - 64'(delta) : 64'(delta);
					quo   = (mag * 64'(evel_pkg::MS_PER_S)) /
						(64'(elapsed) * 64'((edges_r == '0) ? 3'd1 : edges_r));
					rate  = delta[CNT_W-1] ? -longint'(quo) : longint'(quo);
					if (rate > (RF_HI >>> FRAC))
						x = RF_HI;
					else if (rate < -(longint'(1) <<< (evel_pkg::RF_W - 1 - FRAC)))
						x = RF_LO;
					else
						x = rate <<< FRAC;
					acc  = longint'(evel_pkg::W_HI) * filt + longint'(evel_pkg::W_LO) * x +
						longint'(evel_pkg::FILT_ROUND);
					filt = acc >>> evel_pkg::FILT_SHIFT;
					if (filt > RF_HI)
						filt = RF_HI;
					else if (filt < RF_LO)
						filt = RF_LO;
					prev_cnt = cnt;
					last_ms  = ms;
				end
			end

			// unit conversion, truncated toward zero
			per = (ppr_r == '0) ? 64'd1 : 64'(ppr_r);
			case (unit_r)
				evel_pkg::UNIT_REV_MIN: begin
					mul = 64'(evel_pkg::MUL_REV_MIN);
					sh  = 0;
				end
				evel_pkg::UNIT_RAD_S: begin
					mul = 64'(evel_pkg::MUL_RAD_S);
					sh  = evel_pkg::TWO_PI_SHIFT;
				end
				default: begin
					mul = 64'(evel_pkg::MUL_REV_S);
					sh  = 0;
				end
			endcase
			mag = (filt < 0) ? 64'(-filt) : 64'(filt);
			q   = mag / per;
			r   = mag % per;
			lim = (filt < 0) ? (64'd1 << (evel_pkg::RF_W - 1)) :
				(64'd1 << (evel_pkg::RF_W - 1)) - 64'd1;
			// a quotient this big saturates under any multiplier above one
			if (mul > 64'd1 && q >= (64'd1 << (evel_pkg::RF_W - 3))) begin
				res = lim;
			end else begin
				res = (q * mul + (r * mul) / per) >> sh;
				if (res > lim)
					res = lim;
			end
			v.speed = (filt < 0) ? 40'(-res) : 40'(res);

			fr = (filt > FR_HI) ? FR_HI : ((filt < FR_LO) ? FR_LO : filt);
			if (fr != filt)
				n_sat++;
			v.rate = 33'(fr);
			expected_velocity.push_back(v);
		endfunction

		function void log_error(input string msg);
			errors++;
			if (errors <= 10)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(input logic [79:0] data, input logic [0:0] user);
			velocity_t   want;
			logic [32:0] got_rate;
			logic [39:0] got_speed;
			got_rate  = data[32:0];
			got_speed = data[72:33];
			n_checked++;
			if (expected_velocity.size() == 0) begin
				log_error($sformatf("unexpected result rate=%0d speed=%0d zero=%0b",
					$signed(got_rate), $signed(got_speed), user[0]));
				return;
			end
			want = expected_velocity.pop_front();
			if (got_rate !== want.rate || got_speed !== want.speed || user[0] !== want.zero)
				log_error($sformatf(
					"result %0d expected rate=%0d speed=%0d zero=%0b got rate=%0d speed=%0d zero=%0b",
					n_checked, $signed(want.rate), $signed(want.speed), want.zero,
					$signed(got_rate), $signed(got_speed), user[0]));
		endfunction
	endclass

	// -------------------------------------------------------------------------
	// block under test
	// -------------------------------------------------------------------------
	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_addr  = evel_pkg::REG_COUNTING_EDGES;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;    // [15:0] count_value, [47:16] now_ms
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [79:0] m_tdata;           // [32:0] filtered_rate, [72:33] converted_speed
	logic [0:0]  m_tuser;           // [0] zero_interval

	encoder_velocity_estimator_top #(
		.COUNTER_BITS (CNT_W),
		.FRACTION_BITS(FRAC)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	velocity_scoreboard sb;

	// idle percentages, changed per phase by the main sequence
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;

	// running encoder position and time stamp of the stimulus
	logic [CNT_W-1:0] cur_count = '0;
	logic [31:0]      cur_ms    = '0;
	int n_sent     = 0;
	int n_settings = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// output side: check at the edge, then pick next cycle's tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// one sample transaction; valid stays high into the next call when no gap is drawn
	task automatic push_sample(input logic [CNT_W-1:0] cnt, input logic [31:0] ms);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		cur_count = cnt;
		cur_ms    = ms;
		s_tvalid <= 1'b1;
		s_tdata  <= {ms, cnt};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(cnt, ms);
		n_sent++;
	endtask

	// move the encoder by dcount counts over dms milliseconds
	task automatic advance(input int dcount, input logic [31:0] dms);
		push_sample(cur_count + CNT_W'(dcount), cur_ms + dms);
	endtask

	// stop sending and let every outstanding result drain
	task automatic quiesce();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// registers only change while the block sits idle
	task automatic set_config(input logic [15:0] edges, input logic [15:0] ppr,
		input logic [15:0] unit);
		quiesce();
		cfg_put(evel_pkg::REG_COUNTING_EDGES, edges);
		cfg_put(evel_pkg::REG_PULSES_PER_REV, ppr);
		cfg_put(evel_pkg::REG_UNIT_MODE, unit);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// one stretch of motion with a common character
	task automatic run_segment(input int room, output int used);
		int kind, len, speed, dt, jig;
		kind = $urandom_range(0, 9);
		case (kind)
			5, 6:    len = $urandom_range(20, 80);
			default: len = $urandom_range(4, 40);
		endcase
		if (len > room)
			len = room;
		case ($urandom_range(0, 2))
			0:       speed = $urandom_range(0, 50);
			1:       speed = $urandom_range(0, 2000);
			default: speed = $urandom_range(0, 32767);
		endcase
		if ($urandom_range(0, 1))
			speed = -speed;
		for (int i = 0; i < len; i++) begin
			case (kind)
				// flat out at the largest count step each ms, drives the filter toward saturation
				5, 6: advance((speed < 0) ? -32768 : 32767, 1);
				// repeated time stamps in between real moves
				7: begin
					dt = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
					advance(speed * dt, dt);
				end
				// unrelated count and time
				8: push_sample(CNT_W'($urandom), $urandom);
				// huge and wrapping intervals
				9: advance(int'($urandom_range(0, 65535)), $urandom);
				// steady motion with a little jitter, now and then a repeated stamp
				default: begin
					dt  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
					jig = int'($urandom_range(0, 4)) - 2;
					advance(speed * dt + jig, dt);
				end
			endcase
		end
		used = len;
	endtask

	initial begin
		int left, n;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, registers at reset values first
		push_sample(16'h1234, 32'd1000);    // priming sample
		advance(0, 0);                      // repeated stamp right after priming
		advance(100, 1);
		advance(32767, 1);                  // largest forward step
		advance(-32768, 1);                 // half-range step reads as backward
		advance(-1, 1);                     // one count backward
		push_sample(16'hFFFF, 32'hFFFF_FFFF);
		advance(1, 1);                      // count and time both wrap to zero
		advance(5, 32'hFFFF_FFFF);          // longest possible interval
		advance(0, 0);

		// zero edges and zero ppr act as one, unit three acts as rev/s
		set_config(16'd0, 16'd0, 16'd3);
		advance(32767, 1);
		advance(32767, 1);
		advance(32767, 1);
		advance(-32768, 1);

		// upper bits of the narrow registers are ignored
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFE);
		advance(1000, 3);
		advance(-2000, 7);
		advance(0, 0);

		set_config(16'd2, 16'd1, 16'(evel_pkg::UNIT_REV_MIN));
		advance(32767, 1);
		advance(32767, 1);
		advance(-50, 9);

		// random part, idling phases: none, sender, receiver, both
		for (int k = 0; k < N_SETTINGS; k++) begin
			case (k / 2)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 75;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 75;
				end
				default: begin
					src_idle_pct  = 24;
					snk_stall_pct = 24;
				end
			endcase
			case (k)
				0: set_config(16'd1, 16'd1, 16'(evel_pkg::UNIT_REV_MIN));
				1: set_config(16'd4, 16'd1000, 16'(evel_pkg::UNIT_RAD_S));
				2: set_config(16'd2, 16'd65535, 16'(evel_pkg::UNIT_REV_S));
				3: set_config(16'd0, 16'd0, 16'd3);
				4: set_config(16'd7, 16'd360, 16'(evel_pkg::UNIT_REV_MIN));
				default: begin
					case ($urandom_range(0, 2))
						0:       n = 1;
						1:       n = 65535;
						default: n = $urandom_range(0, 65535);
					endcase
					set_config(16'($urandom), 16'(n), 16'($urandom));
				end
			endcase
			left = PER_SETTING;
			while (left > 0) begin
				run_segment(left, n);
				left -= n;
			end
		end

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d samples over %0d register settings, %0d results checked",
			n_sent, n_settings, sb.n_checked);
		$display("zero-interval results %0d, saturated filtered_rate results %0d, errors %0d",
			sb.n_zero, sb.n_sat, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
